// ----- hw/rtl/crcchk_pkg.sv -----
// Shared types, codes, widths and the CRC-32 byte update for the chunk reassembly checker.
package crcchk_pkg;

    localparam int MAX_BLOB_BYTES_DEF = 128 * 1024;

    localparam int REQ_W    = 2;
    localparam int TLEN_W   = 32;
    localparam int CIDX_W   = 16;
    localparam int CBYTES_W = 10;
    localparam int BYTE_W   = 8;
    localparam int CRC_W    = 32;
    localparam int STATUS_W = 4;
    localparam int OFFS_W   = 17;
    localparam int RLEN_W   = 18;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_START = 2'd0,
        REQ_CHUNK = 2'd1,
        REQ_DATA  = 2'd2,
        REQ_END   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_STARTED      = 4'd0,
        ST_SIZE_REJ     = 4'd1,
        ST_CHUNK_OK     = 4'd2,
        ST_OUT_OF_ORDER = 4'd3,
        ST_OVERFLOW     = 4'd4,
        ST_IGNORED      = 4'd5,
        ST_BYTE_STORED  = 4'd6,
        ST_GOOD         = 4'd7,
        ST_BAD          = 4'd8,
        ST_END_IDLE     = 4'd9
    } t_status;

    typedef struct packed {
        t_req                req_type;
        logic [TLEN_W-1:0]   blob_len;
        logic [CIDX_W-1:0]   chunk_index;
        logic [CBYTES_W-1:0] chunk_bytes;
        logic [BYTE_W-1:0]   data_byte;
        logic [CRC_W-1:0]    expected_crc;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [OFFS_W-1:0] byte_offset;
        logic [RLEN_W-1:0] received_len;
        logic [CRC_W-1:0]  computed_crc;
    } t_result;

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] v;
        v = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/crcchk_core.sv -----
// Transfer state, per-word decode and result formation for the chunk reassembly checker.
module crcchk_core #(
    parameter int MAX_BLOB_BYTES = crcchk_pkg::MAX_BLOB_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  crcchk_pkg::t_item    i_item,
    output crcchk_pkg::t_result  o_result
);

    localparam int LEN_W = $clog2(MAX_BLOB_BYTES + 1);
    localparam int CBW   = crcchk_pkg::CBYTES_W;
    localparam int OW    = crcchk_pkg::OFFS_W;
    localparam int RW    = crcchk_pkg::RLEN_W;
    localparam int TLW   = crcchk_pkg::TLEN_W;
    localparam int CIW   = crcchk_pkg::CIDX_W;

    logic                          r_busy, n_busy;
    logic [LEN_W-1:0]              r_stored_len, n_stored_len;
    logic [crcchk_pkg::CIDX_W-1:0] r_next_chunk, n_next_chunk;
    logic [LEN_W-1:0]              r_announced_len, n_announced_len;
    logic [crcchk_pkg::CRC_W-1:0]  r_crc, n_crc;
    logic [CBW-1:0]                r_chunk_left, n_chunk_left;

    crcchk_pkg::t_status           status;
    logic [LEN_W-1:0]              offset;
    logic [LEN_W:0]                fill_sum;
    logic [LEN_W-1:0]              rep_len;
    logic [crcchk_pkg::CRC_W-1:0]  rep_crc;
    logic [LEN_W+RW-1:0]           len_wide;
    logic [LEN_W+OW-1:0]           offs_wide;

    assign fill_sum = {1'b0, r_stored_len} + {{(LEN_W+1-CBW){1'b0}}, i_item.chunk_bytes};

    always_comb begin
        n_busy          = r_busy;
        n_stored_len    = r_stored_len;
        n_next_chunk    = r_next_chunk;
        n_announced_len = r_announced_len;
        n_crc           = r_crc;
        n_chunk_left    = r_chunk_left;
        status          = crcchk_pkg::ST_IGNORED;
        offset          = '0;
        rep_len         = '0;
        rep_crc         = '0;

        unique case (i_item.req_type)
            crcchk_pkg::REQ_START: begin
                n_busy          = 1'b0;
                n_stored_len    = '0;
                n_next_chunk    = '0;
                n_announced_len = '0;
                n_crc           = crcchk_pkg::CRC_INIT;
                n_chunk_left    = '0;
                if (i_item.blob_len == '0 ||
                    i_item.blob_len > TLW'(MAX_BLOB_BYTES)) begin
                    status = crcchk_pkg::ST_SIZE_REJ;
                end else begin
                    n_busy          = 1'b1;
                    n_announced_len = i_item.blob_len[LEN_W-1:0];
                    status          = crcchk_pkg::ST_STARTED;
                end
            end
            crcchk_pkg::REQ_CHUNK: begin
                if (r_busy) begin
                    if (i_item.chunk_index != r_next_chunk ||
                        fill_sum > (LEN_W+1)'(MAX_BLOB_BYTES)) begin
                        n_busy          = 1'b0;
                        n_stored_len    = '0;
                        n_next_chunk    = '0;
                        n_announced_len = '0;
                        n_crc           = crcchk_pkg::CRC_INIT;
                        n_chunk_left    = '0;
                        status = (i_item.chunk_index != r_next_chunk) ?
                                 crcchk_pkg::ST_OUT_OF_ORDER : crcchk_pkg::ST_OVERFLOW;
                    end else begin
                        n_next_chunk = r_next_chunk + CIW'(1);
                        n_chunk_left = i_item.chunk_bytes;
                        status       = crcchk_pkg::ST_CHUNK_OK;
                    end
                end
            end
            crcchk_pkg::REQ_DATA: begin
                if (r_busy && r_chunk_left != '0) begin
                    offset       = r_stored_len;
                    n_crc        = crcchk_pkg::crc_byte(r_crc, i_item.data_byte);
                    n_stored_len = r_stored_len + LEN_W'(1);
                    n_chunk_left = r_chunk_left - CBW'(1);
                    status       = crcchk_pkg::ST_BYTE_STORED;
                end
            end
            crcchk_pkg::REQ_END: begin
                if (r_busy) begin
                    status = (~r_crc == i_item.expected_crc &&
                              r_stored_len == r_announced_len) ?
                             crcchk_pkg::ST_GOOD : crcchk_pkg::ST_BAD;
                end else begin
                    status = crcchk_pkg::ST_END_IDLE;
                end
                n_busy          = 1'b0;
                n_stored_len    = '0;
                n_next_chunk    = '0;
                n_announced_len = '0;
                n_crc           = crcchk_pkg::CRC_INIT;
                n_chunk_left    = '0;
            end
            default: ;
        endcase

        // an end word reports the values it compared, everything else the new state
        if (i_item.req_type == crcchk_pkg::REQ_END) begin
            rep_len = r_stored_len;
            rep_crc = ~r_crc;
        end else begin
            rep_len = n_stored_len;
            rep_crc = ~n_crc;
        end
    end

    assign len_wide  = {{RW{1'b0}}, rep_len};
    assign offs_wide = {{OW{1'b0}}, offset};

    always_comb begin
        o_result.status       = status;
        o_result.byte_offset  = offs_wide[OW-1:0];
        o_result.received_len = len_wide[RW-1:0];
        o_result.computed_crc = rep_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_stored_len    <= '0;
            r_next_chunk    <= '0;
            r_announced_len <= '0;
            r_crc           <= crcchk_pkg::CRC_INIT;
            r_chunk_left    <= '0;
        end else if (i_fire) begin
            r_busy          <= n_busy;
            r_stored_len    <= n_stored_len;
            r_next_chunk    <= n_next_chunk;
            r_announced_len <= n_announced_len;
            r_crc           <= n_crc;
            r_chunk_left    <= n_chunk_left;
        end
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_stored_len == '0 && r_chunk_left == '0))
        else $error("idle with leftover transfer state");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored_len <= LEN_W'(MAX_BLOB_BYTES))
        else $error("stored length beyond capacity");

    a_byte_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && status == crcchk_pkg::ST_BYTE_STORED) |=>
        (r_stored_len == $past(r_stored_len) + LEN_W'(1)))
        else $error("stored byte did not advance length");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.req_type == crcchk_pkg::REQ_END) |=> !r_busy)
        else $error("still busy after end word");

endmodule

// ----- hw/rtl/chunk_reassembly_crc_checker_top.sv -----
// A word accepted into the input register has its result captured in the result register.
// Throughput: one word per cycle while the output is not stalled; the state update and
// byte-wide CRC-32 step sit between the input register and the result register.
// A stalled result holds while one more word waits in the input register.
// Reset (synchronous, active low): idle, CRC all ones, both registers empty.
// Top level of the chunk reassembly CRC-32 checker.
module chunk_reassembly_crc_checker_top #(
    parameter int MAX_BLOB_BYTES = crcchk_pkg::MAX_BLOB_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [crcchk_pkg::REQ_W-1:0]        i_req_type,
    input  logic [crcchk_pkg::TLEN_W-1:0]       i_blob_len,
    input  logic [crcchk_pkg::CIDX_W-1:0]       i_chunk_index,
    input  logic [crcchk_pkg::CBYTES_W-1:0]     i_chunk_bytes,
    input  logic [crcchk_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic [crcchk_pkg::CRC_W-1:0]        i_expected_crc,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [crcchk_pkg::STATUS_W-1:0]     o_status,
    output logic [crcchk_pkg::OFFS_W-1:0]       o_byte_offset,
    output logic [crcchk_pkg::RLEN_W-1:0]       o_received_len,
    output logic [crcchk_pkg::CRC_W-1:0]        o_computed_crc
);

    logic                 r_in_valid;
    crcchk_pkg::t_item    r_in;
    logic                 r_out_valid;
    crcchk_pkg::t_result  r_out;
    crcchk_pkg::t_result  core_result;
    logic                 adv;
    logic                 fire;

    assign adv     = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in.req_type     <= crcchk_pkg::t_req'(i_req_type);
            r_in.blob_len     <= i_blob_len;
            r_in.chunk_index  <= i_chunk_index;
            r_in.chunk_bytes  <= i_chunk_bytes;
            r_in.data_byte    <= i_data_byte;
            r_in.expected_crc <= i_expected_crc;
        end
    end

    crcchk_core #(
        .MAX_BLOB_BYTES(MAX_BLOB_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_byte_offset  = r_out.byte_offset;
    assign o_received_len = r_out.received_len;
    assign o_computed_crc = r_out.computed_crc;

endmodule
